// ===== src/tsbt_pkg.sv =====
// Shared types, constants and codes for the time-sorted bounded record table.
package tsbt_pkg;

    localparam int CAPACITY = 10;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [1:0] {
        KIND_INSERT     = 2'd0,
        KIND_LOOKUP     = 2'd1,
        KIND_SET_STATUS = 2'd2,
        KIND_DELETE     = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        OUT_OK         = 2'd0,
        OUT_NOT_FOUND  = 2'd1,
        OUT_DUPLICATE  = 2'd2,
        OUT_BAD_STATUS = 2'd3
    } outcome_t;

    localparam logic [2:0] STATUS_BOARDING = 3'd0;
    localparam logic [2:0] STATUS_INVALID  = 3'd7;

    typedef struct packed {
        logic [15:0] number;
        logic [7:0]  gate;
        logic [10:0] time_min;
        logic [2:0]  status;
    } rec_t;

    typedef struct packed {
        logic en;
        idx_t addr;
        rec_t data;
    } wr_t;

    typedef struct packed {
        outcome_t outcome;
        logic     evicted;
        rec_t     rec;
    } res_t;

endpackage

// ===== src/time_sorted_bounded_table_top.sv =====
// Time-sorted bounded record table: top level with the result output register.
//
// Input channel s_*: one command per transfer (insert, lookup by number, set
// status, delete). Result channel m_*: exactly one result per command, in order.
// Up to CAPACITY records are kept sorted by time; an insert goes ahead of entries with equal time.
// A non-duplicate insert into a full table evicts the earliest record and reports it.
// A command scans all occupied entries (one per cycle), then an insert or delete
// shifts entries one per cycle through the single register file write port.
// s_ready is high only while the sequencer is idle; one command is in flight.
// The result sits in an output register, so a new command is taken while a
// result still waits; if m_ready stays low, the next result holds in the
// sequencer and input stalls behind it.
// Reset (aresetn low, synchronous) empties the table and drops any pending
// result; record contents are not cleared.
module time_sorted_bounded_table_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [15:0] s_record_number,
    input  logic [7:0]  s_gate,
    input  logic [10:0] s_time_minutes,
    input  logic [2:0]  s_status_code,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_outcome,
    output logic        m_evicted,
    output logic [15:0] m_entry_number,
    output logic [7:0]  m_entry_gate,
    output logic [10:0] m_entry_time,
    output logic [2:0]  m_entry_status
);

    tsbt_pkg::wr_t  wr;
    tsbt_pkg::idx_t rd_addr;
    tsbt_pkg::rec_t rd_data;
    tsbt_pkg::res_t res;
    logic           res_valid;
    logic           res_ready;
    logic           m_valid_reg;
    tsbt_pkg::res_t out_reg;

    tsbt_store u_store (
        .aclk    (aclk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    tsbt_seq u_seq (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_record_number (s_record_number),
        .s_gate          (s_gate),
        .s_time_minutes  (s_time_minutes),
        .s_status_code   (s_status_code),
        .wr              (wr),
        .rd_addr         (rd_addr),
        .rd_data         (rd_data),
        .res_valid       (res_valid),
        .res_ready       (res_ready),
        .res             (res)
    );

    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_outcome      = out_reg.outcome;
    assign m_evicted      = out_reg.evicted;
    assign m_entry_number = out_reg.rec.number;
    assign m_entry_gate   = out_reg.rec.gate;
    assign m_entry_time   = out_reg.rec.time_min;
    assign m_entry_status = out_reg.rec.status;

endmodule

// ===== src/tsbt_store.sv =====
// Record register file: one write port, one read port, no reset on contents.
module tsbt_store (
    input  logic           aclk,
    input  tsbt_pkg::wr_t  wr,
    input  tsbt_pkg::idx_t rd_addr,
    output tsbt_pkg::rec_t rd_data
);

    tsbt_pkg::rec_t entries [tsbt_pkg::CAPACITY];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            entries[wr.addr] <= wr.data;
        end
    end

    assign rd_data = entries[rd_addr];

endmodule

// ===== src/tsbt_seq.sv =====
// Sequencer: scans the table one entry per cycle, then shifts and writes entries.
module tsbt_seq (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic [1:0]     s_kind,
    input  logic [15:0]    s_record_number,
    input  logic [7:0]     s_gate,
    input  logic [10:0]    s_time_minutes,
    input  logic [2:0]     s_status_code,
    output tsbt_pkg::wr_t  wr,
    output tsbt_pkg::idx_t rd_addr,
    input  tsbt_pkg::rec_t rd_data,
    output logic           res_valid,
    input  logic           res_ready,
    output tsbt_pkg::res_t res
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_SHIFT_UP,
        ST_SHIFT_DN,
        ST_RESP
    } state_t;

    state_t           state_reg, state_next;
    tsbt_pkg::kind_t  kind_reg, kind_next;
    logic [15:0]      num_reg, num_next;
    logic [7:0]       gate_reg, gate_next;
    logic [10:0]      tm_reg, tm_next;
    logic [2:0]       st_reg, st_next;
    tsbt_pkg::cnt_t   occ_reg, occ_next;
    tsbt_pkg::cnt_t   idx_reg, idx_next;
    tsbt_pkg::cnt_t   pos_reg, pos_next;
    tsbt_pkg::cnt_t   lim_reg, lim_next;
    logic             posf_reg, posf_next;
    logic             found_reg, found_next;
    logic             ins_reg, ins_next;
    tsbt_pkg::cnt_t   slot_reg, slot_next;
    tsbt_pkg::rec_t   slot_rec_reg, slot_rec_next;
    tsbt_pkg::rec_t   first_rec_reg, first_rec_next;
    tsbt_pkg::res_t   res_reg, res_next;

    tsbt_pkg::cnt_t   idx_inc, idx_dec;
    tsbt_pkg::rec_t   new_rec, upd_rec;

    assign idx_inc = idx_reg + 1'b1;
    assign idx_dec = idx_reg - 1'b1;

    always_comb begin
        new_rec.number   = num_reg;
        new_rec.gate     = gate_reg;
        new_rec.time_min = tm_reg;
        new_rec.status   = (st_reg == tsbt_pkg::STATUS_INVALID) ?
                           tsbt_pkg::STATUS_BOARDING : st_reg;
        upd_rec          = slot_rec_reg;
        upd_rec.status   = st_reg;
    end

    always_comb begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        num_next       = num_reg;
        gate_next      = gate_reg;
        tm_next        = tm_reg;
        st_next        = st_reg;
        occ_next       = occ_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        lim_next       = lim_reg;
        posf_next      = posf_reg;
        found_next     = found_reg;
        ins_next       = ins_reg;
        slot_next      = slot_reg;
        slot_rec_next  = slot_rec_reg;
        first_rec_next = first_rec_reg;
        res_next       = res_reg;
        wr             = '0;
        rd_addr        = idx_reg[tsbt_pkg::IDX_W-1:0];

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    kind_next  = tsbt_pkg::kind_t'(s_kind);
                    num_next   = s_record_number;
                    gate_next  = s_gate;
                    tm_next    = s_time_minutes;
                    st_next    = s_status_code;
                    idx_next   = '0;
                    pos_next   = occ_reg;
                    posf_next  = 1'b0;
                    found_next = 1'b0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (idx_reg == occ_reg) begin
                    state_next = ST_DECIDE;
                end else begin
                    // first matching number and first entry not earlier than the new time
                    if (!found_reg && rd_data.number == num_reg) begin
                        found_next    = 1'b1;
                        slot_next     = idx_reg;
                        slot_rec_next = rd_data;
                    end
                    if (!posf_reg && !(tm_reg > rd_data.time_min)) begin
                        posf_next = 1'b1;
                        pos_next  = idx_reg;
                    end
                    if (idx_reg == '0) begin
                        first_rec_next = rd_data;
                    end
                    idx_next = idx_inc;
                end
            end
            ST_DECIDE: begin
                res_next.outcome = tsbt_pkg::OUT_OK;
                res_next.evicted = 1'b0;
                res_next.rec     = '0;
                state_next       = ST_RESP;
                if (kind_reg == tsbt_pkg::KIND_INSERT) begin
                    if (found_reg) begin
                        res_next.outcome = tsbt_pkg::OUT_DUPLICATE;
                        res_next.rec     = slot_rec_reg;
                    end else if (occ_reg < tsbt_pkg::cnt_t'(tsbt_pkg::CAPACITY)) begin
                        idx_next   = occ_reg;
                        state_next = ST_SHIFT_UP;
                    end else if (pos_reg == '0) begin
                        // new record is the earliest: it is evicted at once
                        res_next.evicted = 1'b1;
                        res_next.rec     = new_rec;
                    end else begin
                        res_next.evicted = 1'b1;
                        res_next.rec     = first_rec_reg;
                        idx_next         = '0;
                        lim_next         = pos_reg - 1'b1;
                        ins_next         = 1'b1;
                        state_next       = ST_SHIFT_DN;
                    end
                end else if (!found_reg) begin
                    res_next.outcome = tsbt_pkg::OUT_NOT_FOUND;
                end else begin
                    case (kind_reg)
                        tsbt_pkg::KIND_LOOKUP: begin
                            res_next.rec = slot_rec_reg;
                        end
                        tsbt_pkg::KIND_SET_STATUS: begin
                            if (st_reg == tsbt_pkg::STATUS_INVALID) begin
                                res_next.outcome = tsbt_pkg::OUT_BAD_STATUS;
                                res_next.rec     = slot_rec_reg;
                            end else begin
                                wr.en        = 1'b1;
                                wr.addr      = slot_reg[tsbt_pkg::IDX_W-1:0];
                                wr.data      = upd_rec;
                                res_next.rec = upd_rec;
                            end
                        end
                        default: begin
                            // delete: close the gap from the slot upward
                            res_next.rec = slot_rec_reg;
                            idx_next     = slot_reg;
                            lim_next     = occ_reg - 1'b1;
                            ins_next     = 1'b0;
                            occ_next     = occ_reg - 1'b1;
                            state_next   = ST_SHIFT_DN;
                        end
                    endcase
                end
            end
            ST_SHIFT_UP: begin
                if (idx_reg == pos_reg) begin
                    wr.en      = 1'b1;
                    wr.addr    = pos_reg[tsbt_pkg::IDX_W-1:0];
                    wr.data    = new_rec;
                    occ_next   = occ_reg + 1'b1;
                    state_next = ST_RESP;
                end else begin
                    rd_addr  = idx_dec[tsbt_pkg::IDX_W-1:0];
                    wr.en    = 1'b1;
                    wr.addr  = idx_reg[tsbt_pkg::IDX_W-1:0];
                    wr.data  = rd_data;
                    idx_next = idx_dec;
                end
            end
            ST_SHIFT_DN: begin
                if (idx_reg == lim_reg) begin
                    if (ins_reg) begin
                        wr.en   = 1'b1;
                        wr.addr = lim_reg[tsbt_pkg::IDX_W-1:0];
                        wr.data = new_rec;
                    end
                    state_next = ST_RESP;
                end else begin
                    rd_addr  = idx_inc[tsbt_pkg::IDX_W-1:0];
                    wr.en    = 1'b1;
                    wr.addr  = idx_reg[tsbt_pkg::IDX_W-1:0];
                    wr.data  = rd_data;
                    idx_next = idx_inc;
                end
            end
            ST_RESP: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            occ_reg   <= '0;
        end else begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
        end
        kind_reg      <= kind_next;
        num_reg       <= num_next;
        gate_reg      <= gate_next;
        tm_reg        <= tm_next;
        st_reg        <= st_next;
        idx_reg       <= idx_next;
        pos_reg       <= pos_next;
        lim_reg       <= lim_next;
        posf_reg      <= posf_next;
        found_reg     <= found_next;
        ins_reg       <= ins_next;
        slot_reg      <= slot_next;
        slot_rec_reg  <= slot_rec_next;
        first_rec_reg <= first_rec_next;
        res_reg       <= res_next;
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_RESP);
    assign res       = res_reg;

endmodule
